// File: rtl/tgs_pkg.sv
`timescale 1ns / 1ps
package tgs_pkg;

   localparam int GRID_X_DEF = 16;
   localparam int GRID_Y_DEF = 16;
   localparam int GRID_Z_DEF = 16;

   localparam int ADDR_W  = 12;
   localparam int CELL_W  = 8;
   localparam int FRAC_W  = 17;
   localparam int CSR_W   = 3;
   localparam int CORNERS = 8;

   localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;
   localparam logic [31:0] INV_SPACING_RESET = 32'h0001_0000;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [CSR_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_W-1:0] CSR_INV_X    = 3'd3;
   localparam logic [CSR_W-1:0] CSR_INV_Y    = 3'd4;
   localparam logic [CSR_W-1:0] CSR_INV_Z    = 3'd5;

   typedef struct packed {
      logic               kind;
      logic [ADDR_W-1:0]  node_index;
      logic signed [31:0] node_vel_x;
      logic signed [31:0] node_vel_y;
      logic signed [31:0] node_vel_z;
      logic signed [31:0] node_press;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_payload_type;

   typedef struct packed {
      logic               in_bounds;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] pressure;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] press;
   } node_type;

   function automatic logic signed [31:0] node_field(input node_type n, input int q);
      logic signed [31:0] v;
      case (q)
         0: v = n.vel_x;
         1: v = n.vel_y;
         2: v = n.vel_z;
         default: v = n.press;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/tgs_axis.sv
`timescale 1ns / 1ps
module tgs_axis #(
   parameter int GRID = tgs_pkg::GRID_X_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [31:0]            pos,
   input  logic signed [31:0]            origin,
   input  logic [31:0]                   inv_spacing,
   output logic [tgs_pkg::CELL_W-1:0]    cell_idx,
   output logic [tgs_pkg::FRAC_W-1:0]    frac,
   output logic                          ok
);
   import tgs_pkg::*;

   localparam logic [48:0] LIM = 49'(GRID - 1) << 16;

   logic signed [32:0] diff_in, diff_ff;
   logic [47:0]        hi_in, hi_ff, lo_in, lo_ff;
   logic               neg_ff;
   logic [48:0]        n_in;
   logic [CELL_W-1:0]  cell_in, cell_ff;
   logic [FRAC_W-1:0]  frac_in, frac_ff;
   logic               ok_in, ok_ff;

   assign diff_in = 33'(pos) - 33'(origin);
   assign hi_in   = 48'(diff_ff[31:16]) * 48'(inv_spacing);
   assign lo_in   = 48'(diff_ff[15:0]) * 48'(inv_spacing);
   assign n_in    = 49'(hi_ff) + 49'(lo_ff[47:16]);

   always_comb begin
      ok_in = !neg_ff && (n_in <= LIM);
      // far face: clamp to last cell at full weight
      if (n_in[48:16] > 33'(GRID - 2)) begin
         cell_in = CELL_W'(GRID - 2);
         frac_in = ONE_Q16;
      end else begin
         cell_in = n_in[16 +: CELL_W];
         frac_in = {1'b0, n_in[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         neg_ff  <= diff_ff[32];
         cell_ff <= cell_in;
         frac_ff <= frac_in;
         ok_ff   <= ok_in;
      end
   end

   assign cell_idx = cell_ff;
   assign frac     = frac_ff;
   assign ok       = ok_ff;

endmodule

// File: rtl/tgs_store.sv
`timescale 1ns / 1ps
module tgs_store (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [tgs_pkg::ADDR_W-1:0]                      wr_addr,
   input  tgs_pkg::node_type                               wr_data,
   input  logic                                            rd_en,
   input  logic [tgs_pkg::CORNERS-1:0][tgs_pkg::ADDR_W-1:0] rd_addr,
   output tgs_pkg::node_type [tgs_pkg::CORNERS-1:0]        rd_data
);
   import tgs_pkg::*;

   // one copy of the node store per cell corner, all written together
   for (genvar c = 0; c < CORNERS; c++) begin : g_bank
      node_type mem [2**ADDR_W];
      node_type rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_data;
         end
      end

      always_ff @(posedge clock) begin
         if (rd_en) begin
            rd_ff <= mem[rd_addr[c]];
         end
      end

      assign rd_data[c] = rd_ff;
   end

endmodule

// File: rtl/tgs_lerp.sv
`timescale 1ns / 1ps
module tgs_lerp (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [31:0]         a,
   input  logic signed [31:0]         b,
   input  logic [tgs_pkg::FRAC_W-1:0] f,
   output logic signed [31:0]         y
);
   import tgs_pkg::*;

   logic [FRAC_W-1:0]  w;
   logic signed [49:0] pa_in, pb_in, pa_ff, pb_ff;
   logic signed [50:0] sum_in;
   logic signed [31:0] y_ff;

   assign w      = ONE_Q16 - f;
   assign pa_in  = a * $signed({1'b0, w});
   assign pb_in  = b * $signed({1'b0, f});
   // round half up, then floor by the shift
   assign sum_in = 51'(pa_ff) + 51'(pb_ff) + 51'(32768);

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         y_ff  <= sum_in[47:16];
      end
   end

   assign y = y_ff;

endmodule

// File: rtl/trilinear_grid_sampler_unit.sv
`timescale 1ns / 1ps
// Channel  Ports                                   Beat
// req      req_valid/req_ready/req_data            load one node or query one position
// rsp      rsp_valid/rsp_ready/rsp_data            one result per query beat
// csr      csr_valid/csr_ready/csr_index/csr_data  register write, always ready
//
// One beat per cycle in while no held result stalls the pipeline.
// Ten register stages: the 3-stage coordinate map, the store read and three
// 2-stage lerp levels. Loads pass three stages, then write all eight store copies.
// Reset clears valid bits and origins, sets inverse spacings to 1; store not cleared.
// A held result stalls the whole pipeline; req_ready drops with it.
module trilinear_grid_sampler_unit #(
   parameter int GRID_X = tgs_pkg::GRID_X_DEF,
   parameter int GRID_Y = tgs_pkg::GRID_Y_DEF,
   parameter int GRID_Z = tgs_pkg::GRID_Z_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tgs_pkg::req_payload_type   req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tgs_pkg::rsp_payload_type   rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [tgs_pkg::CSR_W-1:0]  csr_index,
   input  logic [31:0]                csr_data
);
   import tgs_pkg::*;

   localparam int DEPTH = 10;

   logic               pipe_en;
   logic [DEPTH-1:0]   valid_ff;
   logic signed [31:0] org_x_ff, org_y_ff, org_z_ff;
   logic [31:0]        inv_x_ff, inv_y_ff, inv_z_ff;

   logic [CELL_W-1:0]  cx, cy, cz;
   logic [FRAC_W-1:0]  fx, fy, fz;
   logic               okx, oky, okz;

   logic [FRAC_W-1:0]  fx_ff;
   logic [FRAC_W-1:0]  fy_ff [3];
   logic [FRAC_W-1:0]  fz_ff [5];
   logic [6:0]         ok_ff;

   logic [CORNERS-1:0][ADDR_W-1:0] rd_addr;
   node_type [CORNERS-1:0]         rd_data;
   node_type                       wr_data;

   logic [2:0]         ld_v_ff;
   logic [ADDR_W-1:0]  ld_addr_ff [3];
   node_type           ld_data_ff [3];

   logic signed [31:0] lx [4][4];
   logic signed [31:0] ly [4][2];
   logic signed [31:0] lz [4];

   assign pipe_en   = !valid_ff[DEPTH-1] || rsp_ready;
   assign req_ready = pipe_en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         inv_x_ff <= INV_SPACING_RESET;
         inv_y_ff <= INV_SPACING_RESET;
         inv_z_ff <= INV_SPACING_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_X: org_x_ff <= csr_data;
            CSR_ORIGIN_Y: org_y_ff <= csr_data;
            CSR_ORIGIN_Z: org_z_ff <= csr_data;
            CSR_INV_X:    inv_x_ff <= csr_data;
            CSR_INV_Y:    inv_y_ff <= csr_data;
            CSR_INV_Z:    inv_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_valid && req_data.kind == KIND_QUERY};
      end
   end

   tgs_axis #(.GRID(GRID_X)) u_axis_x (
      .clock(clock), .en(pipe_en), .pos(req_data.pos_x), .origin(org_x_ff),
      .inv_spacing(inv_x_ff), .cell_idx(cx), .frac(fx), .ok(okx)
   );
   tgs_axis #(.GRID(GRID_Y)) u_axis_y (
      .clock(clock), .en(pipe_en), .pos(req_data.pos_y), .origin(org_y_ff),
      .inv_spacing(inv_y_ff), .cell_idx(cy), .frac(fy), .ok(oky)
   );
   tgs_axis #(.GRID(GRID_Z)) u_axis_z (
      .clock(clock), .en(pipe_en), .pos(req_data.pos_z), .origin(org_z_ff),
      .inv_spacing(inv_z_ff), .cell_idx(cz), .frac(fz), .ok(okz)
   );

   // corner c: bit 0 steps i, bit 1 steps j, bit 2 steps k; wrap to store size
   always_comb begin
      for (int c = 0; c < CORNERS; c++) begin
         rd_addr[c] = ADDR_W'(32'(cx) + 32'(c % 2)
                      + GRID_X * (32'(cy) + 32'((c / 2) % 2)
                      + GRID_Y * (32'(cz) + 32'(c / 4))));
      end
   end

   assign wr_data.vel_x = req_data.node_vel_x;
   assign wr_data.vel_y = req_data.node_vel_y;
   assign wr_data.vel_z = req_data.node_vel_z;
   assign wr_data.press = req_data.node_press;

   // hold each load three stages so it lands in beat order with query reads
   always_ff @(posedge clock) begin
      if (reset) begin
         ld_v_ff <= '0;
      end else if (pipe_en) begin
         ld_v_ff <= {ld_v_ff[1:0], req_valid && req_data.kind == KIND_LOAD};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ld_addr_ff[0] <= req_data.node_index;
         ld_data_ff[0] <= wr_data;
         for (int s = 1; s < 3; s++) begin
            ld_addr_ff[s] <= ld_addr_ff[s-1];
            ld_data_ff[s] <= ld_data_ff[s-1];
         end
      end
   end

   tgs_store u_store (
      .clock(clock),
      .wr_en(ld_v_ff[2] && pipe_en),
      .wr_addr(ld_addr_ff[2]),
      .wr_data(ld_data_ff[2]),
      .rd_en(pipe_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fx_ff    <= fx;
         fy_ff[0] <= fy;
         fy_ff[1] <= fy_ff[0];
         fy_ff[2] <= fy_ff[1];
         fz_ff[0] <= fz;
         for (int s = 1; s < 5; s++) begin
            fz_ff[s] <= fz_ff[s-1];
         end
         ok_ff <= {ok_ff[5:0], okx && oky && okz};
      end
   end

   for (genvar q = 0; q < 4; q++) begin : g_q
      for (genvar p = 0; p < 4; p++) begin : g_x
         tgs_lerp u_lerp_x (
            .clock(clock), .en(pipe_en),
            .a(node_field(rd_data[p*2], q)), .b(node_field(rd_data[p*2+1], q)),
            .f(fx_ff), .y(lx[q][p])
         );
      end
      for (genvar z = 0; z < 2; z++) begin : g_y
         tgs_lerp u_lerp_y (
            .clock(clock), .en(pipe_en),
            .a(lx[q][z*2]), .b(lx[q][z*2+1]), .f(fy_ff[2]), .y(ly[q][z])
         );
      end
      tgs_lerp u_lerp_z (
         .clock(clock), .en(pipe_en),
         .a(ly[q][0]), .b(ly[q][1]), .f(fz_ff[4]), .y(lz[q])
      );
   end

   assign rsp_valid          = valid_ff[DEPTH-1];
   assign rsp_data.in_bounds = ok_ff[6];
   assign rsp_data.vel_x     = ok_ff[6] ? lz[0] : '0;
   assign rsp_data.vel_y     = ok_ff[6] ? lz[1] : '0;
   assign rsp_data.vel_z     = ok_ff[6] ? lz[2] : '0;
   assign rsp_data.pressure  = ok_ff[6] ? lz[3] : '0;

`ifndef NO_ASSERTIONS
   a_query_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_QUERY |=> valid_ff[0])
      else $error("query beat did not enter the pipeline");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_LOAD |=> !valid_ff[0])
      else $error("load beat entered the result pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(valid_ff))
      else $error("pipeline moved during a stall");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> fx_ff <= ONE_Q16)
      else $error("x weight above one");
`endif

endmodule

// File: tb/sv/tb_trilinear_grid_sampler_unit.sv
`timescale 1ns / 1ps
module tb_trilinear_grid_sampler_unit;
   import tgs_pkg::*;

   localparam int GX = GRID_X_DEF;
   localparam int GY = GRID_Y_DEF;
   localparam int GZ = GRID_Z_DEF;
   localparam int NODES = GX * GY * GZ;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REQ_W = $bits(req_payload_type);

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   req_payload_type req_data;
   logic rsp_valid, rsp_ready;
   rsp_payload_type rsp_data;
   logic csr_valid, csr_ready;
   logic [CSR_W-1:0] csr_index;
   logic [31:0] csr_data;

   trilinear_grid_sampler_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic signed [31:0] grid_origin [3];
   logic [31:0] grid_inv [3];
   logic signed [31:0] grid_nodes [NODES][4];
   bit node_written [NODES];
   rsp_payload_type samples_pending [$];

   int send_idle_pct;
   int recv_stall_pct;
   int error_count = 0;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // map one axis; returns 0 when outside the grid
   function automatic bit map_axis(input logic signed [31:0] pos,
                                   input logic signed [31:0] org,
                                   input logic [31:0] inv, input int grid,
                                   output int cix, output longint frac);
      longint d;
      longint unsigned ud, n;
      d = longint'(pos) - longint'(org);
      if (d < 0) return 1'b0;
      ud = d;
      n = (ud >> 16) * inv + (((ud & 64'hFFFF) * inv) >> 16);
      if (n > (longint'(grid - 1) << 16)) return 1'b0;
      if ((n >> 16) > grid - 2) begin
         cix = grid - 2;
         frac = 65536;
      end else begin
         cix = int'(n >> 16);
         frac = longint'(n & 64'hFFFF);
      end
      return 1'b1;
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint f);
      longint w;
      w = a * (65536 - f) + b * f + 32768;
      if (w >= 0) return w >>> 16;
      return -(((-w) + 65535) >>> 16);
   endfunction

   function automatic longint node_at(input int i, input int j, input int k, input int q);
      return grid_nodes[(i + GX * (j + GY * k)) & 12'hFFF][q];
   endfunction

   function automatic rsp_payload_type sample_grid(input req_payload_type r);
      rsp_payload_type s;
      int ci, cj, ck;
      longint fx, fy, fz, c00, c10, c01, c11, c0, c1;
      logic [31:0] v [4];
      s = '0;
      if (!map_axis(r.pos_x, grid_origin[0], grid_inv[0], GX, ci, fx)) return s;
      if (!map_axis(r.pos_y, grid_origin[1], grid_inv[1], GY, cj, fy)) return s;
      if (!map_axis(r.pos_z, grid_origin[2], grid_inv[2], GZ, ck, fz)) return s;
      for (int q = 0; q < 4; q++) begin
         c00 = blend(node_at(ci, cj, ck, q), node_at(ci + 1, cj, ck, q), fx);
         c10 = blend(node_at(ci, cj + 1, ck, q), node_at(ci + 1, cj + 1, ck, q), fx);
         c01 = blend(node_at(ci, cj, ck + 1, q), node_at(ci + 1, cj, ck + 1, q), fx);
         c11 = blend(node_at(ci, cj + 1, ck + 1, q),
                     node_at(ci + 1, cj + 1, ck + 1, q), fx);
         c0 = blend(c00, c10, fy);
         c1 = blend(c01, c11, fy);
         v[q] = 32'(blend(c0, c1, fz));
      end
      s.in_bounds = 1'b1;
      s.vel_x = v[0];
      s.vel_y = v[1];
      s.vel_z = v[2];
      s.pressure = v[3];
      return s;
   endfunction

   // true unless an in-bounds query would blend a node never loaded
   function automatic bit corners_loaded(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
      int ci, cj, ck, idx;
      longint fx, fy, fz;
      if (!map_axis(x, grid_origin[0], grid_inv[0], GX, ci, fx)) return 1'b1;
      if (!map_axis(y, grid_origin[1], grid_inv[1], GY, cj, fy)) return 1'b1;
      if (!map_axis(z, grid_origin[2], grid_inv[2], GZ, ck, fz)) return 1'b1;
      for (int c = 0; c < 8; c++) begin
         idx = (ci + c % 2 + GX * (cj + (c / 2) % 2 + GY * (ck + c / 4))) & 12'hFFF;
         if (!node_written[idx]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic send_beat(input req_payload_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (r.kind == KIND_LOAD) begin
         grid_nodes[r.node_index][0] = r.node_vel_x;
         grid_nodes[r.node_index][1] = r.node_vel_y;
         grid_nodes[r.node_index][2] = r.node_vel_z;
         grid_nodes[r.node_index][3] = r.node_press;
         node_written[r.node_index] = 1'b1;
      end else begin
         samples_pending = {samples_pending, sample_grid(r)};
      end
   endtask

   task automatic load_node(input int idx, input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic [31:0] d);
      req_payload_type r;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom});
      r.kind = KIND_LOAD;
      r.node_index = ADDR_W'(idx);
      r.node_vel_x = a;
      r.node_vel_y = b;
      r.node_vel_z = c;
      r.node_press = d;
      send_beat(r);
   endtask

   task automatic query_at(input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
      req_payload_type r;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom});
      r.kind = KIND_QUERY;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      send_beat(r);
   endtask

   // fall back to the grid origin, whose cell is always loaded
   task automatic query_checked(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z);
      if (corners_loaded(x, y, z)) query_at(x, y, z);
      else query_at(grid_origin[0], grid_origin[1], grid_origin[2]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (samples_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx <= CSR_ORIGIN_Z) grid_origin[idx] = val;
      else grid_inv[idx - CSR_INV_X] = val;
   endtask

   task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] oz, input logic [31:0] ix,
                           input logic [31:0] iy, input logic [31:0] iz);
      wait_drained();
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_ORIGIN_Z, oz);
      write_csr(CSR_INV_X, ix);
      write_csr(CSR_INV_Y, iy);
      write_csr(CSR_INV_Z, iz);
      csr_valid <= 1'b0;
   endtask

   // loaded nodes per axis: the first four and the last four
   function automatic int band_node(input int m, input int grid);
      return (m < 4) ? m : grid - 8 + m;
   endfunction

   // node-space coordinate whose cell lies inside the loaded bands
   function automatic longint band_coord(input int grid);
      if ($urandom_range(1) == 0) return $urandom_range((3 << 16) - 1);
      return $urandom_range((grid - 1) << 16, (grid - 4) << 16);
   endfunction

   // node-space coordinate (Q16.16) to a position under the current registers
   // only valid for the default unit spacing
   function automatic logic [31:0] rand_coord(input int grid);
      case ($urandom_range(5))
         0: return 32'h0;
         1: return (grid - 1) << 16;
         2: return ((grid - 1) << 16) + 1;
         3: return 32'hFFFF_FFFF;
         4: return $urandom;
         default: return 32'(band_coord(grid));
      endcase
   endfunction

   task automatic test_fill_grid();
      for (int k = 0; k < 8; k++)
         for (int j = 0; j < 8; j++)
            for (int i = 0; i < 8; i++)
               load_node(band_node(i, GX) + GX * (band_node(j, GY) + GY * band_node(k, GZ)),
                         $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic test_directed();
      load_node(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
      load_node(NODES - 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1);
      query_at(0, 0, 0);
      query_at(15 << 16, 15 << 16, 15 << 16);
      query_at((15 << 16) + 1, 0, 0);
      query_at(0, 32'hFFFF_FFFF, 0);
      query_at(0, 0, 32'h8000_0000);
      query_at(32'h7FFF_FFFF, 0, 0);
      query_at(32'h0001_8000, 32'h000E_FFFF, 32'h0000_0001);
      query_at(32'h000F_0000, 32'h0000_8000, 32'h000E_0000);
      query_at(32'h000E_FFFF, 32'h000E_FFFF, 32'h000E_FFFF);
      query_at(32'h0002_4000, 32'h000C_C000, 32'h000D_2000);
   endtask

   task automatic test_random_unit(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0)
            load_node($urandom_range(NODES - 1), $urandom, $urandom, $urandom, $urandom);
         else
            query_checked(rand_coord(GX), rand_coord(GY), rand_coord(GZ));
      end
   endtask

   // arbitrary registers: position picked from a node-space target
   task automatic test_random_scaled(input int count);
      logic [31:0] p [3];
      longint t, d;
      int g;
      for (int n = 0; n < count; n++) begin
         for (int a = 0; a < 3; a++) begin
            g = (a == 0) ? GX : (a == 1) ? GY : GZ;
            if (grid_inv[a] == 0 || $urandom_range(7) == 0) p[a] = $urandom;
            else begin
               t = band_coord(g);
               if ($urandom_range(5) == 0) t = (g - 1) << 16;
               d = (t << 16) / grid_inv[a];
               p[a] = 32'(longint'(grid_origin[a]) + d);
            end
         end
         query_checked(p[0], p[1], p[2]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (samples_pending.size() == 0) begin
            $error("result with nothing expected");
            error_count++;
         end else begin
            want = samples_pending.pop_front();
            if (rsp_data.in_bounds !== want.in_bounds) begin
               $error("in_bounds exp %0d got %0d", want.in_bounds, rsp_data.in_bounds);
               error_count++;
            end
            if (rsp_data.vel_x !== want.vel_x) begin
               $error("vel_x exp %0d got %0d", want.vel_x, rsp_data.vel_x);
               error_count++;
            end
            if (rsp_data.vel_y !== want.vel_y) begin
               $error("vel_y exp %0d got %0d", want.vel_y, rsp_data.vel_y);
               error_count++;
            end
            if (rsp_data.vel_z !== want.vel_z) begin
               $error("vel_z exp %0d got %0d", want.vel_z, rsp_data.vel_z);
               error_count++;
            end
            if (rsp_data.pressure !== want.pressure) begin
               $error("pressure exp %0d got %0d", want.pressure, rsp_data.pressure);
               error_count++;
            end
         end
      end
   end

   // watchdog: count cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int a = 0; a < 3; a++) begin
         grid_origin[a] = '0;
         grid_inv[a] = INV_SPACING_RESET;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_grid();
      test_directed();
      test_random_unit(300);
      send_idle_pct = 64;
      test_random_unit(200);
      // hold off until every result is back
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 64;
      test_random_unit(200);
      send_idle_pct = 27;
      recv_stall_pct = 27;
      set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF0_0000, 32'h1, 32'hFFFF_FFFF,
               32'h0000_8000);
      query_checked(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF0_0000);
      query_checked(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      test_random_scaled(200);
      set_grid(32'hFFFE_0000, 32'h0001_8000, 32'h0, 32'h0, 32'h0002_0000,
               32'h0000_0001);
      test_random_scaled(200);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_grid($urandom, $urandom, $urandom, $urandom_range(32'h0004_0000, 32'h100),
               $urandom_range(32'h0004_0000, 32'h100), $urandom);
      test_random_scaled(150);
      set_grid(0, 0, 0, INV_SPACING_RESET, INV_SPACING_RESET, INV_SPACING_RESET);
      test_random_unit(200);

      wait_drained();
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
